### rtl/sha256cr_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 compression rounds package
// Word widths, round constant table, initial hash value and the round
// functions shared by the compression rounds unit.
// ----------------------------------------------------------------------------
package sha256cr_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NUM_WORDS  = 8;
    localparam int unsigned ROUND_W    = 6;
    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned CFG_IDX_W  = $clog2(NUM_WORDS);
    localparam int unsigned OUT_DATA_W = WORD_W * NUM_WORDS;

    localparam logic [ROUND_W-1:0] FIRST_ROUND = '0;
    localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(NUM_ROUNDS - 1);
    localparam logic [ROUND_W-1:0] ROUND_STEP  = ROUND_W'(1);

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_WORDS-1:0] word_set_t;

    // Initial hash value, chaining words 0..7
    localparam word_set_t CHAIN_IV = '{
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Round constants, entry 0 first
    localparam word_t ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Big sigma 0: rotate right by 2, 13, 22
    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Big sigma 1: rotate right by 6, 11, 25
    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

### rtl/sha256_compression_rounds_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 compression rounds unit
// Applies one SHA-256 round per schedule word and emits the eight working
// words after every 64th word.
// ----------------------------------------------------------------------------
// One schedule word is taken per clock cycle unless the input is stalled;
// each word runs one full round (round constant lookup, sigma/choose/
// majority, modular adds) combinationally straight into the working
// registers a..h. Words 0..63 of a block are numbered by an internal round
// counter; on round 0 the working words start from the chaining registers
// init_a..init_h, which are written through the cfg port and take effect at
// the next block start. In the cycle after the 64th word is taken, the final
// a..h appear on the output stream and are held in an output register until
// taken, while the next block keeps streaming in. Input is stalled only when
// a finished result is still unread and the word now offered would complete
// another block.
module sha256_compression_rounds_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write port
    input  logic                                   cfg_we,
    input  logic [sha256cr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sha256cr_pkg::WORD_W-1:0]        cfg_data,
    // Schedule word stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [sha256cr_pkg::WORD_W-1:0]        s_axis_tdata,  // [31:0] sched_word
    // Result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [sha256cr_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // out_a..out_h,
                                                                  // 32 bits each, a lowest
);

    sha256cr_pkg::word_set_t                chain_reg;
    sha256cr_pkg::word_set_t                work_reg;
    sha256cr_pkg::word_set_t                work_next;
    sha256cr_pkg::word_set_t                out_reg;
    logic [sha256cr_pkg::ROUND_W-1:0]       round_reg;
    logic                                   out_valid_reg;

    sha256cr_pkg::word_set_t                cur;
    sha256cr_pkg::word_t                    t1;
    sha256cr_pkg::word_t                    t2;
    logic                                   in_fire;
    logic                                   last_round;

    assign last_round    = (round_reg == sha256cr_pkg::LAST_ROUND);
    assign s_axis_tready = !out_valid_reg || m_axis_tready || !last_round;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Select round inputs: chaining words at block start, else working words
    always_comb
    begin
        cur = (round_reg == sha256cr_pkg::FIRST_ROUND) ? chain_reg : work_reg;
        t1  = cur[7] + sha256cr_pkg::big_sigma1(cur[4])
            + sha256cr_pkg::choose(cur[4], cur[5], cur[6])
            + sha256cr_pkg::ROUND_K[round_reg] + s_axis_tdata;
        t2  = sha256cr_pkg::big_sigma0(cur[0])
            + sha256cr_pkg::majority(cur[0], cur[1], cur[2]);
        work_next[7] = cur[6];
        work_next[6] = cur[5];
        work_next[5] = cur[4];
        work_next[4] = cur[3] + t1;
        work_next[3] = cur[2];
        work_next[2] = cur[1];
        work_next[1] = cur[0];
        work_next[0] = t1 + t2;
    end

    // Hold chaining registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= sha256cr_pkg::CHAIN_IV;
        end
        else if (cfg_we)
        begin
            chain_reg[cfg_index] <= cfg_data;
        end
    end

    // Advance round counter and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg     <= sha256cr_pkg::FIRST_ROUND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                round_reg <= round_reg + sha256cr_pkg::ROUND_STEP;
            end
            if (in_fire && last_round)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Update working words and capture the finished block
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            work_reg <= work_next;
            if (last_round)
            begin
                out_reg <= work_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression rounds unit testbench
// Streams schedule words into the unit and compares every eight-word result
// against a round-by-round predictor kept alongside. The chaining registers
// are reprogrammed between phases, often partway through a block, and both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TARGET_WORDS    = 1700;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int QUIET_LIMIT     = 2000;

    // Chaining register indexes on the cfg port
    typedef enum logic [sha256cr_pkg::CFG_IDX_W-1:0] {
        REG_INIT_A, REG_INIT_B, REG_INIT_C, REG_INIT_D,
        REG_INIT_E, REG_INIT_F, REG_INIT_G, REG_INIT_H
    } chain_reg_e;

    // Ways of loading the chaining registers between phases
    typedef enum int {
        CHAIN_ZERO, CHAIN_ONES, CHAIN_RANDOM, CHAIN_IV, CHAIN_MIXED
    } chain_setting_e;

    localparam sha256cr_pkg::word_t SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam sha256cr_pkg::word_t SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Directed schedule words: all-zero, all-one, lone bits, alternating
    // patterns and carry-heavy values, run against the reset chaining value
    localparam sha256cr_pkg::word_t DIRECTED_WORDS [25] = '{
        32'h00000000, 32'hffffffff, 32'h00000001, 32'h80000000,
        32'h7fffffff, 32'hfffffffe, 32'h55555555, 32'haaaaaaaa,
        32'h0000ffff, 32'hffff0000, 32'h00ff00ff, 32'hff00ff00,
        32'h0f0f0f0f, 32'hf0f0f0f0, 32'h33333333, 32'hcccccccc,
        32'h80000001, 32'h7ffffffe, 32'h00000000, 32'h00000000,
        32'hffffffff, 32'hffffffff, 32'h12345678, 32'hdeadbeef,
        32'h01234567
    };

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_we;
    logic [sha256cr_pkg::CFG_IDX_W-1:0]  cfg_index;
    sha256cr_pkg::word_t                 cfg_data;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    sha256cr_pkg::word_t                 s_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [sha256cr_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Predictor state
    sha256cr_pkg::word_t      chain_words [8];
    sha256cr_pkg::word_t      work_words [8];
    logic [5:0]               round_ctr;
    sha256cr_pkg::word_set_t  expected_digests [$];

    int  digests_predicted = 0;
    int  words_sent = 0;
    int  error_count = 0;
    bit  tx_gaps_on = 1'b1;
    bit  rx_stalls_on = 1'b1;
    bit  hold_off_req = 1'b0;

    sha256_compression_rounds_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic sha256cr_pkg::word_t rotr(input sha256cr_pkg::word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Offer one schedule word and hold it until taken
    task automatic send_word(input sha256cr_pkg::word_t w);
        int gap;
        gap = tx_gaps_on ? draw_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom();
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
    endtask

    // Drop valid, wait for every pending digest, then let the unit settle
    task automatic drain_unit();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_digests.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Track register writes, run the round model on each accepted word and
    // compare each taken result with the oldest predicted digest
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        sha256cr_pkg::word_t     s1, ch, t1, s0, mj;
        sha256cr_pkg::word_set_t digest;
        sha256cr_pkg::word_set_t got;
        int                      i;
        if (!rst_n)
        begin
            for (i = 0; i < 8; i++)
            begin
                chain_words[i] = SHA_IV[i];
                work_words[i]  = '0;
            end
            round_ctr = '0;
        end
        else
        begin
            if (cfg_we)
                chain_words[cfg_index] = cfg_data;

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (round_ctr == 6'd0)
                    work_words = chain_words;
                s1 = rotr(work_words[4], 6) ^ rotr(work_words[4], 11)
                   ^ rotr(work_words[4], 25);
                ch = (work_words[4] & work_words[5]) ^ (~work_words[4] & work_words[6]);
                t1 = work_words[7] + s1 + ch + SHA_K[round_ctr] + s_axis_tdata;
                s0 = rotr(work_words[0], 2) ^ rotr(work_words[0], 13)
                   ^ rotr(work_words[0], 22);
                mj = (work_words[0] & work_words[1]) ^ (work_words[0] & work_words[2])
                   ^ (work_words[1] & work_words[2]);
                work_words[7] = work_words[6];
                work_words[6] = work_words[5];
                work_words[5] = work_words[4];
                work_words[4] = work_words[3] + t1;
                work_words[3] = work_words[2];
                work_words[2] = work_words[1];
                work_words[1] = work_words[0];
                work_words[0] = t1 + s0 + mj;
                if (round_ctr == 6'd63)
                begin
                    for (i = 0; i < 8; i++)
                        digest[i] = work_words[i];
                    expected_digests.push_back(digest);
                    digests_predicted++;
                end
                round_ctr = round_ctr + 6'd1;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_digests.size() == 0)
                    report_mismatch($sformatf("result %064h with no block pending", got));
                else
                begin
                    digest = expected_digests.pop_front();
                    for (i = 0; i < 8; i++)
                        if (got[i] !== digest[i])
                            report_mismatch($sformatf("out_%c got %08h, expected %08h",
                                                      8'h61 + i, got[i], digest[i]));
                end
            end
        end
    end

    // Result sink: random stalls, plus a long hold-off on request
    initial
    begin : result_sink
        int hold;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (!rx_stalls_on)
                m_axis_tready <= 1'b1;
            else
            begin
                hold = draw_gap();
                if (hold == 0)
                    m_axis_tready <= 1'b1;
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat (hold - 1) @(posedge clk);
                end
            end
        end
    end

    // End the run if nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        chain_setting_e      setting;
        chain_reg_e          order [8];
        chain_reg_e          tmp_reg;
        sha256cr_pkg::word_t value;
        sha256cr_pkg::word_t w;
        bit                  pressure;
        int                  phase;
        int                  n;
        int                  k;
        int                  j;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_INIT_A;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words, reset chaining value
        for (k = 0; k < 25; k++)
            send_word(DIRECTED_WORDS[k]);

        // Random phases; each ends at an arbitrary round, so the new
        // chaining value is written while a block is part way through
        phase = 0;
        while (words_sent < TARGET_WORDS)
        begin
            drain_unit();

            if (phase < 5)
                setting = chain_setting_e'(phase);
            else
                setting = chain_setting_e'($urandom_range(0, 4));

            // Shuffle the write order
            for (k = 0; k < 8; k++)
                order[k] = chain_reg_e'(k);
            for (k = 7; k > 0; k--)
            begin
                j = $urandom_range(0, k);
                tmp_reg = order[k];
                order[k] = order[j];
                order[j] = tmp_reg;
            end

            // Throwaway write first, overwritten by the full set below
            cfg_we    <= 1'b1;
            cfg_index <= chain_reg_e'($urandom_range(0, 7));
            cfg_data  <= $urandom();
            @(posedge clk);
            for (k = 0; k < 8; k++)
            begin
                case (setting)
                    CHAIN_ZERO:   value = '0;
                    CHAIN_ONES:   value = '1;
                    CHAIN_RANDOM: value = $urandom();
                    CHAIN_IV:     value = SHA_IV[order[k]];
                    default:
                    begin
                        case ($urandom_range(0, 2))
                            0:       value = '0;
                            1:       value = '1;
                            default: value = $urandom();
                        endcase
                    end
                endcase
                cfg_index <= order[k];
                cfg_data  <= value;
                @(posedge clk);
            end
            cfg_we <= 1'b0;

            // Pressure phases: sender streams flat out while the sink holds off
            pressure     = (phase == 1) || (phase == 6);
            tx_gaps_on   = !pressure && ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if (pressure)
            begin
                hold_off_req = 1'b1;
                n = 420;
            end
            else
                n = $urandom_range(70, 330);

            for (k = 0; k < n; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       w = '0;
                    1:       w = '1;
                    2:       w = 32'h1 << $urandom_range(0, 31);
                    default: w = $urandom();
                endcase
                send_word(w);
            end
            phase++;
        end

        drain_unit();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/sha256cr_pkg.sv
rtl/sha256_compression_rounds_unit.sv
sim/testbench.sv
